// ===== sv/bpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants of the bivariate polynomial multiplier mod p.
// ----------------------------------------------------------------------------
package bpm_pkg;

    // coefficient and position widths
    localparam int COEF_W   = 30;
    localparam int POS_W    = 2;
    localparam int PPOS_W   = 3;
    localparam int BIT_W    = $clog2(COEF_W);

    // modulus after reset
    localparam logic [COEF_W-1:0] MOD_RESET = 30'd65521;

    // one request to the modular add/double unit: result = (2*acc or acc) + addend mod p
    typedef struct packed {
        logic              dbl;
        logic [COEF_W-1:0] acc;
        logic [COEF_W-1:0] addend;
    } step_req_t;

endpackage

// ===== sv/bivariate_poly_mul_mod_p.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bivariate_poly_mul_mod_p
// Schoolbook multiplier of two bivariate polynomials with coefficients mod p.
// ----------------------------------------------------------------------------
// Each load item writes one coefficient of a and of b at (y_row, x_col); both
// are reduced mod p on entry, out-of-range positions are dropped. The item
// with final_load set starts the product c = a*b, emitted row by row up to the
// highest nonzero row, all 2*X_TERMS-1 columns per row; an all-zero product
// gives one item with zero_product set. The factors are cleared afterwards.
// All arithmetic runs through one bit-serial modular double-and-add unit, one
// bit per cycle. A load item reduces a, then b, bit by bit, and stores each
// reduced factor. A product scans, per output coefficient, all Y_TERMS*X_TERMS
// term pairs; each pair whose factors are both nonzero is multiplied
// bit-serially and added to the accumulator, then the coefficient is written.
// Each result item is read from the product memory, then loaded into the output
// register. load_stall is high after acceptance until the block is idle again.
// ----------------------------------------------------------------------------
module bivariate_poly_mul_mod_p #(
    parameter int Y_TERMS = 4,
    parameter int X_TERMS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bpm_pkg::COEF_W-1:0]  modulus,
    // load items
    input  logic                        load_valid,
    output logic                        load_stall,
    input  logic [bpm_pkg::POS_W-1:0]   y_row,
    input  logic [bpm_pkg::POS_W-1:0]   x_col,
    input  logic [bpm_pkg::COEF_W-1:0]  a_coef,
    input  logic [bpm_pkg::COEF_W-1:0]  b_coef,
    input  logic                        final_load,
    // product items
    output logic                        prod_valid,
    input  logic                        prod_stall,
    output logic [bpm_pkg::PPOS_W-1:0]  prod_row,
    output logic [bpm_pkg::PPOS_W-1:0]  prod_col,
    output logic [bpm_pkg::COEF_W-1:0]  prod_coef,
    output logic                        zero_product,
    output logic                        run_end
);
    import bpm_pkg::*;

    // geometry
    localparam int N   = Y_TERMS * X_TERMS;
    localparam int AW  = (N > 1) ? $clog2(N) : 1;
    localparam int PY  = 2 * Y_TERMS - 1;
    localparam int PX  = 2 * X_TERMS - 1;
    localparam int PN  = PY * PX;
    localparam int PAW = (PN > 1) ? $clog2(PN) : 1;

    localparam logic [PPOS_W-1:0] YT   = PPOS_W'(Y_TERMS);
    localparam logic [PPOS_W-1:0] XT   = PPOS_W'(X_TERMS);
    localparam logic [PPOS_W-1:0] PY_L = PPOS_W'(PY - 1);
    localparam logic [PPOS_W-1:0] PX_L = PPOS_W'(PX - 1);
    localparam logic [POS_W-1:0]  YM1  = POS_W'(Y_TERMS - 1);
    localparam logic [POS_W-1:0]  XM1  = POS_W'(X_TERMS - 1);
    localparam logic [BIT_W-1:0]  BIT_TOP = BIT_W'(COEF_W - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_REDA  = 4'd1;
    localparam logic [3:0] S_REDB  = 4'd2;
    localparam logic [3:0] S_MSEL  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_CWR   = 4'd6;
    localparam logic [3:0] S_ERD   = 4'd7;
    localparam logic [3:0] S_EOUT  = 4'd8;
    localparam logic [3:0] S_EZERO = 4'd9;

    // control registers
    logic [3:0]        state_reg, state_next;
    logic [COEF_W-1:0] modulus_reg;
    logic [N-1:0]      valid_reg, valid_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [POS_W-1:0]  i_reg, i_next, k_reg, k_next;
    logic [PPOS_W-1:0] y_reg, y_next, x_reg, x_next;
    logic [PAW-1:0]    paddr_reg, paddr_next;
    logic [PPOS_W-1:0] top_reg, top_next;
    logic              nz_reg, nz_next;
    logic              prod_valid_reg;

    // datapath registers
    logic [POS_W-1:0]  ld_row_reg, ld_col_reg;
    logic [COEF_W-1:0] ld_a_reg, ld_b_reg;
    logic              ld_final_reg;
    logic [COEF_W-1:0] r_reg, r_next;
    logic [COEF_W-1:0] acc_reg, acc_next;
    logic [COEF_W-1:0] opa_reg, opb_reg;
    logic [COEF_W-1:0] a_store [N];
    logic [COEF_W-1:0] b_store [N];
    logic [COEF_W-1:0] prod_mem [PN];
    logic [COEF_W-1:0] rdata_reg;
    logic [PPOS_W-1:0] prod_row_reg, prod_col_reg;
    logic [COEF_W-1:0] prod_coef_reg;
    logic              zero_product_reg, run_end_reg;

    // strobes
    logic load_acc, out_free;
    logic a_wr, b_wr, op_ld, mem_wr, out_ld, out_zero, out_last;

    // shared unit
    step_req_t         step_req;
    logic [COEF_W-1:0] step_res;

    // addressing
    logic              ld_in_range;
    logic [AW-1:0]     ld_idx, a_idx, b_idx;
    logic [PPOS_W:0]   j_s, l_s;
    logic              pair_ok, pair_last;
    logic [COEF_W-1:0] a_val, b_val;
    logic              acc_nz, emit_last;

    assign cfg_ready  = 1'b1;
    assign load_stall = (state_reg != S_IDLE);
    assign load_acc   = load_valid && !load_stall;
    assign out_free   = !prod_valid_reg || !prod_stall;

    // load position
    assign ld_in_range = ({1'b0, ld_row_reg} < YT) && ({1'b0, ld_col_reg} < XT);
    assign ld_idx      = AW'(int'(ld_row_reg) * X_TERMS + int'(ld_col_reg));

    // term pair (i,k) x (j,l) for output cell (y,x)
    assign j_s = {1'b0, y_reg} - {2'b00, i_reg};
    assign l_s = {1'b0, x_reg} - {2'b00, k_reg};
    assign pair_ok = !j_s[PPOS_W] && (j_s[PPOS_W-1:0] < YT)
                  && !l_s[PPOS_W] && (l_s[PPOS_W-1:0] < XT);
    assign pair_last = (i_reg == YM1) && (k_reg == XM1);
    assign a_idx = AW'(int'(i_reg) * X_TERMS + int'(k_reg));
    assign b_idx = AW'(int'(j_s[POS_W-1:0]) * X_TERMS + int'(l_s[POS_W-1:0]));
    assign a_val = valid_reg[a_idx] ? a_store[a_idx] : '0;
    assign b_val = valid_reg[b_idx] ? b_store[b_idx] : '0;

    assign acc_nz    = (acc_reg != '0);
    assign emit_last = (y_reg == top_reg) && (x_reg == PX_L);

    // operand select for the shared unit
    always_comb
    begin
        step_req.dbl    = 1'b1;
        step_req.acc    = r_reg;
        step_req.addend = '0;
        unique case (state_reg)
            S_REDA:  step_req.addend = {{(COEF_W-1){1'b0}}, ld_a_reg[bit_reg]};
            S_REDB:  step_req.addend = {{(COEF_W-1){1'b0}}, ld_b_reg[bit_reg]};
            S_MUL:   step_req.addend = opb_reg[bit_reg] ? opa_reg : '0;
            S_ACC:
            begin
                step_req.dbl    = 1'b0;
                step_req.acc    = acc_reg;
                step_req.addend = r_reg;
            end
            default: step_req.addend = '0;
        endcase
    end

    bpm_modstep u_step (
        .req     (step_req),
        .modulus (modulus_reg),
        .result  (step_res)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        bit_next   = bit_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        y_next     = y_reg;
        x_next     = x_reg;
        paddr_next = paddr_reg;
        top_next   = top_reg;
        nz_next    = nz_reg;
        r_next     = r_reg;
        acc_next   = acc_reg;
        a_wr       = 1'b0;
        b_wr       = 1'b0;
        op_ld      = 1'b0;
        mem_wr     = 1'b0;
        out_ld     = 1'b0;
        out_zero   = 1'b0;
        out_last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load_acc)
                begin
                    state_next = S_REDA;
                    bit_next   = BIT_TOP;
                    r_next     = '0;
                end
            end
            // reduce a, one bit per cycle, MSB first
            S_REDA:
            begin
                r_next = step_res;
                if (bit_reg == '0)
                begin
                    a_wr       = 1'b1;
                    r_next     = '0;
                    bit_next   = BIT_TOP;
                    state_next = S_REDB;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            // reduce b, then store the pair
            S_REDB:
            begin
                r_next = step_res;
                if (bit_reg == '0)
                begin
                    b_wr = 1'b1;
                    if (ld_in_range)
                    begin
                        valid_next[ld_idx] = 1'b1;
                    end
                    if (ld_final_reg)
                    begin
                        state_next = S_MSEL;
                        y_next     = '0;
                        x_next     = '0;
                        i_next     = '0;
                        k_next     = '0;
                        acc_next   = '0;
                        paddr_next = '0;
                        nz_next    = 1'b0;
                        top_next   = '0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            // pick next term pair; skip missing or zero terms
            S_MSEL:
            begin
                if (pair_ok && (a_val != '0) && (b_val != '0))
                begin
                    op_ld      = 1'b1;
                    r_next     = '0;
                    bit_next   = BIT_TOP;
                    state_next = S_MUL;
                end
                else if (pair_last)
                begin
                    state_next = S_CWR;
                end
                else if (k_reg == XM1)
                begin
                    k_next = '0;
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            // interleaved modular multiply, one bit of b per cycle
            S_MUL:
            begin
                r_next = step_res;
                if (bit_reg == '0)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            // accumulate and advance to the next pair
            S_ACC:
            begin
                acc_next = step_res;
                if (pair_last)
                begin
                    state_next = S_CWR;
                end
                else
                begin
                    state_next = S_MSEL;
                    if (k_reg == XM1)
                    begin
                        k_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            // write finished coefficient, track highest nonzero row
            S_CWR:
            begin
                mem_wr     = 1'b1;
                acc_next   = '0;
                i_next     = '0;
                k_next     = '0;
                paddr_next = paddr_reg + 1'b1;
                state_next = S_MSEL;
                if (acc_nz)
                begin
                    nz_next  = 1'b1;
                    top_next = y_reg;
                end
                if (x_reg == PX_L)
                begin
                    x_next = '0;
                    if (y_reg == PY_L)
                    begin
                        y_next     = '0;
                        paddr_next = '0;
                        valid_next = '0;
                        state_next = (nz_reg || acc_nz) ? S_ERD : S_EZERO;
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            // memory read latency
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_free)
                begin
                    out_ld     = 1'b1;
                    out_last   = emit_last;
                    paddr_next = paddr_reg + 1'b1;
                    state_next = emit_last ? S_IDLE : S_ERD;
                    if (x_reg == PX_L)
                    begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                end
            end
            S_EZERO:
            begin
                if (out_free)
                begin
                    out_ld     = 1'b1;
                    out_zero   = 1'b1;
                    out_last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            modulus_reg    <= MOD_RESET;
            valid_reg      <= '0;
            bit_reg        <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            y_reg          <= '0;
            x_reg          <= '0;
            paddr_reg      <= '0;
            top_reg        <= '0;
            nz_reg         <= 1'b0;
            prod_valid_reg <= 1'b0;
            r_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            bit_reg   <= bit_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            y_reg     <= y_next;
            x_reg     <= x_next;
            paddr_reg <= paddr_next;
            top_reg   <= top_next;
            nz_reg    <= nz_next;
            r_reg     <= r_next;
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg <= modulus;
            end
            if (out_ld)
            begin
                prod_valid_reg <= 1'b1;
            end
            else if (!prod_stall)
            begin
                prod_valid_reg <= 1'b0;
            end
        end
    end

    // load capture, factor stores, operands, accumulator
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (load_acc)
        begin
            ld_row_reg   <= y_row;
            ld_col_reg   <= x_col;
            ld_a_reg     <= a_coef;
            ld_b_reg     <= b_coef;
            ld_final_reg <= final_load;
        end
        if (a_wr && ld_in_range)
        begin
            a_store[ld_idx] <= step_res;
        end
        if (b_wr && ld_in_range)
        begin
            b_store[ld_idx] <= step_res;
        end
        if (op_ld)
        begin
            opa_reg <= a_val;
            opb_reg <= b_val;
        end
    end

    // product memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            prod_mem[paddr_reg] <= acc_reg;
        end
        rdata_reg <= prod_mem[paddr_reg];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_ld)
        begin
            prod_row_reg     <= out_zero ? '0 : y_reg;
            prod_col_reg     <= out_zero ? '0 : x_reg;
            prod_coef_reg    <= out_zero ? '0 : rdata_reg;
            zero_product_reg <= out_zero;
            run_end_reg      <= out_last;
        end
    end

    assign prod_valid   = prod_valid_reg;
    assign prod_row     = prod_row_reg;
    assign prod_col     = prod_col_reg;
    assign prod_coef    = prod_coef_reg;
    assign zero_product = zero_product_reg;
    assign run_end      = run_end_reg;

    // an accepted load keeps the block busy on the next cycle
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (load_valid && !load_stall) |=> load_stall)
        else $error("block not busy after accepting a load item");

    // a zero product is a single all-zero item that ends the run
    a_zero_item: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid && zero_product) |-> (run_end && (prod_coef == '0)
                                         && (prod_row == '0) && (prod_col == '0)))
        else $error("malformed zero-product item");

    // multiplier result is reduced before accumulation
    a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ACC) && (modulus_reg >= COEF_W'(2))) |-> (r_reg < modulus_reg))
        else $error("multiply result not below modulus");

endmodule

// ===== sv/bpm_modstep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_modstep
// Modular double-and-add step: (dbl ? 2*acc : acc) + addend, reduced mod p.
// Inputs satisfy acc < p and addend < p, so two conditional subtracts suffice.
// ----------------------------------------------------------------------------
module bpm_modstep (
    input  bpm_pkg::step_req_t          req,
    input  logic [bpm_pkg::COEF_W-1:0]  modulus,
    output logic [bpm_pkg::COEF_W-1:0]  result
);
    import bpm_pkg::*;

    logic [COEF_W+1:0] sum;
    logic [COEF_W+1:0] p_ext;
    logic [COEF_W+1:0] s1;
    logic [COEF_W+1:0] s2;

    // raw sum, below 3p
    assign sum   = (req.dbl ? {1'b0, req.acc, 1'b0} : {2'b00, req.acc}) + {2'b00, req.addend};
    assign p_ext = {2'b00, modulus};

    // bring back below p
    assign s1 = (sum >= p_ext) ? (sum - p_ext) : sum;
    assign s2 = (s1 >= p_ext) ? (s1 - p_ext) : s1;

    // modulus 0 or 1 maps everything to zero
    assign result = (modulus < COEF_W'(2)) ? '0 : s2[COEF_W-1:0];

endmodule
